// ----- rtl/pixel_replicate_upscaler_defines.svh -----
// assertion macros shared by prus_queue and prus_back
`ifndef PIXEL_REPLICATE_UPSCALER_DEFINES_SVH
`define PIXEL_REPLICATE_UPSCALER_DEFINES_SVH

// same-cycle implication
`define PRUS_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PRUS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/prus_pkg.sv -----
package prus_pkg;

   localparam int PIXEL_W      = 24;
   localparam int SCALE_REG_W  = 5;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int ROW_W        = 12;
   localparam int MAX_HEIGHT   = 4096;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = HEIGHT_REG_W;
   localparam int USER_W       = 5;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_SCALE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IN_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IN_HEIGHT = 2'd2;

   typedef enum logic {
      CMD_PUSH  = 1'b0,
      CMD_DRAIN = 1'b1
   } prus_cmd_type;

   typedef struct packed {
      logic                   we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } prus_csr_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               row_end;
      logic [1:0]         pad_bytes;
      logic               frame_end;
      logic               error;
   } prus_job_type;

   typedef struct packed {
      logic       error;
      logic       frame_end;
      logic [1:0] pad_bytes;
      logic       row_end;
   } prus_user_type;

endpackage

// ----- rtl/prus_ram.sv -----
module prus_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/prus_queue.sv -----
`include "pixel_replicate_upscaler_defines.svh"

module prus_queue import prus_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  prus_job_type wr_data,
   output logic         full,
   input  logic         rd_en,
   output prus_job_type rd_data,
   output logic         not_empty
);

   prus_job_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_en ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (!wr_en && rd_en) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];

   `PRUS_ASSERT(a_no_overflow, full, !wr_en)
   `PRUS_ASSERT(a_no_underflow, !not_empty, !rd_en)

endmodule

// ----- rtl/prus_front.sv -----
module prus_front import prus_pkg::*; #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_SCALE = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  prus_csr_type                     csr,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [PIXEL_W-1:0]               req_tdata,
   input  logic [0:0]                       req_tuser,
   output logic                             q_wr_en,
   output prus_job_type                     q_wr_data,
   input  logic                             q_full,
   output logic [$clog2(MAX_SCALE+1)-1:0]   eff_scale
);

   localparam int SW = $clog2(MAX_SCALE + 1);
   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
                       $clog2(MAX_WIDTH + 1) : WIDTH_REG_W;

   logic [SCALE_REG_W-1:0]  scale_ff;
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;

   logic [CW-1:0]    col_ff, col_in;
   logic [CW-1:0]    rcol_ff, rcol_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [SW-1:0]    rows_left_ff, rows_left_in;

   logic         stage_v_ff, stage_v_in;
   logic         from_ram_ff, from_ram_in;
   prus_job_type job_ff, job_in;

   logic [SW-1:0]           eff_s;
   logic [WW-1:0]           eff_w;
   logic [HEIGHT_REG_W-1:0] eff_h;
   logic [1:0]              pad;
   logic                    last_row;
   logic                    col_end;
   logic                    rcol_end;
   logic [ROW_W-1:0]        next_row;
   prus_cmd_type            cmd;
   logic                    is_push;
   logic                    err;
   logic                    accept;
   logic                    stage_move;
   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [PIXEL_W-1:0]      ram_rd_data;

   // clamp the registers to their usable ranges
   always_comb begin
      if (scale_ff == '0) begin
         eff_s = SW'(1);
      end else if (int'(scale_ff) > MAX_SCALE) begin
         eff_s = SW'(MAX_SCALE);
      end else begin
         eff_s = SW'(scale_ff);
      end
      if (width_ff == '0) begin
         eff_w = WW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HEIGHT_REG_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign pad       = 2'(eff_w[1:0] * 2'(eff_s));
   assign last_row  = (HEIGHT_REG_W'(row_ff) + HEIGHT_REG_W'(1)) >= eff_h;
   assign col_end   = (WW'(col_ff) + WW'(1)) >= eff_w;
   assign rcol_end  = (WW'(rcol_ff) + WW'(1)) >= eff_w;
   assign next_row  = last_row ? '0 : ROW_W'(row_ff + 1'b1);
   assign eff_scale = eff_s;

   assign cmd        = prus_cmd_type'(req_tuser[0]);
   assign is_push    = (cmd == CMD_PUSH);
   assign err        = is_push != (rows_left_ff == '0);
   assign stage_move = stage_v_ff && !q_full;
   assign req_tready = !stage_v_ff || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign ram_wr_en  = accept && is_push && !err;
   assign ram_rd_en  = accept && !is_push && !err;

   always_comb begin
      col_in       = col_ff;
      rcol_in      = rcol_ff;
      row_in       = row_ff;
      rows_left_in = rows_left_ff;
      if (ram_wr_en) begin
         if (col_end) begin
            col_in = '0;
            if (eff_s > SW'(1)) begin
               rows_left_in = SW'(eff_s - 1'b1);
               rcol_in      = '0;
            end else begin
               row_in = next_row;
            end
         end else begin
            col_in = CW'(col_ff + 1'b1);
         end
      end else if (ram_rd_en) begin
         if (rcol_end) begin
            rcol_in      = '0;
            rows_left_in = SW'(rows_left_ff - 1'b1);
            if (rows_left_ff == SW'(1)) begin
               row_in = next_row;
            end
         end else begin
            rcol_in = CW'(rcol_ff + 1'b1);
         end
      end
   end

   always_comb begin
      stage_v_in  = stage_v_ff;
      from_ram_in = from_ram_ff;
      job_in      = job_ff;
      if (accept) begin
         stage_v_in  = 1'b1;
         from_ram_in = ram_rd_en;
         job_in      = '0;
         if (err) begin
            job_in.error = 1'b1;
         end else if (is_push) begin
            job_in.pixel     = req_tdata;
            job_in.row_end   = col_end;
            job_in.pad_bytes = col_end ? pad : 2'b00;
            job_in.frame_end = col_end && (eff_s == SW'(1)) && last_row;
         end else begin
            job_in.row_end   = rcol_end;
            job_in.pad_bytes = rcol_end ? pad : 2'b00;
            job_in.frame_end = rcol_end && (rows_left_ff == SW'(1)) && last_row;
         end
      end else if (stage_move) begin
         stage_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_REG_W'(1);
         width_ff     <= WIDTH_REG_W'(1);
         height_ff    <= HEIGHT_REG_W'(1);
         col_ff       <= '0;
         rcol_ff      <= '0;
         row_ff       <= '0;
         rows_left_ff <= '0;
         stage_v_ff   <= 1'b0;
      end else begin
         if (csr.we && csr.index == REG_SCALE) begin
            scale_ff <= csr.wdata[SCALE_REG_W-1:0];
         end
         if (csr.we && csr.index == REG_IN_WIDTH) begin
            width_ff <= csr.wdata[WIDTH_REG_W-1:0];
         end
         if (csr.we && csr.index == REG_IN_HEIGHT) begin
            height_ff <= csr.wdata[HEIGHT_REG_W-1:0];
         end
         col_ff       <= col_in;
         rcol_ff      <= rcol_in;
         row_ff       <= row_in;
         rows_left_ff <= rows_left_in;
         stage_v_ff   <= stage_v_in;
      end
   end

   always_ff @(posedge clock) begin
      from_ram_ff <= from_ram_in;
      job_ff      <= job_in;
   end

   prus_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (col_ff),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (rcol_ff),
      .rd_data (ram_rd_data)
   );

   // replayed pixels come from the buffer read, valid in the cycle after the tick
   always_comb begin
      q_wr_data = job_ff;
      if (from_ram_ff) begin
         q_wr_data.pixel = ram_rd_data;
      end
   end

   assign q_wr_en = stage_move;

endmodule

// ----- rtl/prus_back.sv -----
`include "pixel_replicate_upscaler_defines.svh"

module prus_back import prus_pkg::*; #(
   parameter int MAX_SCALE = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(MAX_SCALE+1)-1:0] eff_scale,
   input  logic                           q_valid,
   input  prus_job_type                   q_data,
   output logic                           q_rd_en,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [PIXEL_W-1:0]             rsp_tdata,
   output logic                           rsp_tlast,
   output logic [USER_W-1:0]              rsp_tuser
);

   localparam int SW = $clog2(MAX_SCALE + 1);

   logic          cur_v_ff, cur_v_in;
   prus_job_type  cur_ff, cur_in;
   logic [SW-1:0] rem_ff, rem_in;

   logic          last;
   logic          fire;
   logic          load;
   prus_user_type user;

   assign last = (rem_ff == '0);
   assign fire = rsp_tvalid && rsp_tready;
   assign load = q_valid && (!cur_v_ff || (fire && last));

   always_comb begin
      cur_v_in = cur_v_ff;
      cur_in   = cur_ff;
      rem_in   = rem_ff;
      if (load) begin
         cur_v_in = 1'b1;
         cur_in   = q_data;
         rem_in   = q_data.error ? '0 : SW'(eff_scale - 1'b1);
      end else if (fire) begin
         if (last) begin
            cur_v_in = 1'b0;
         end else begin
            rem_in = SW'(rem_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_v_ff <= 1'b0;
         rem_ff   <= '0;
      end else begin
         cur_v_ff <= cur_v_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // row and frame flags ride on the last copy only
   always_comb begin
      user.error     = cur_ff.error;
      user.frame_end = cur_ff.frame_end && last;
      user.pad_bytes = last ? cur_ff.pad_bytes : 2'b00;
      user.row_end   = cur_ff.row_end && last;
   end

   assign q_rd_en    = load;
   assign rsp_tvalid = cur_v_ff;
   assign rsp_tdata  = cur_ff.pixel;
   assign rsp_tlast  = last;
   assign rsp_tuser  = user;

   `PRUS_ASSERT_NEXT(a_run_continues, fire && !last, rsp_tvalid)
   `PRUS_ASSERT(a_frame_on_row_end, rsp_tvalid && user.frame_end, user.row_end)
   `PRUS_ASSERT(a_error_single, rsp_tvalid && cur_ff.error, last && !user.row_end)

endmodule

// ----- rtl/pixel_replicate_upscaler.sv -----
// Integer nearest-neighbor upscaler for 24-bit pixels. A push item stores the
// pixel in the line buffer and produces scale copies as part of the first
// output row; once a row is complete, scale-1 replays are owed and each drain
// item produces scale copies of the next buffered pixel. Results leave one per
// cycle from the output run counter while rsp_tready is high, so an item
// yields scale results at the output (1 to 16); an out of turn command
// yields a single error item. The front stage accepts a new item every cycle
// while the four-entry queue in front of the run counter has room, so the
// sustained rate is set by the run counter alone. A replayed pixel is read
// from the line buffer in the cycle after its drain item is taken. The line
// buffer is not cleared after reset. Configuration writes take effect at the
// next item and should be made only while the block is idle.
module pixel_replicate_upscaler import prus_pkg::*; #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_SCALE = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // pixel_in
   input  logic [0:0]             req_tuser,   // command
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [PIXEL_W-1:0]     rsp_tdata,   // pixel_out
   output logic                   rsp_tlast,
   output logic [USER_W-1:0]      rsp_tuser    // row_end, pad_bytes, frame_end, error
);

   localparam int SW = $clog2(MAX_SCALE + 1);

   prus_csr_type  csr;
   logic          q_wr_en;
   prus_job_type  q_wr_data;
   logic          q_full;
   logic          q_rd_en;
   prus_job_type  q_rd_data;
   logic          q_not_empty;
   logic [SW-1:0] eff_scale;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   prus_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_wr_en    (q_wr_en),
      .q_wr_data  (q_wr_data),
      .q_full     (q_full),
      .eff_scale  (eff_scale)
   );

   prus_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (q_wr_en),
      .wr_data   (q_wr_data),
      .full      (q_full),
      .rd_en     (q_rd_en),
      .rd_data   (q_rd_data),
      .not_empty (q_not_empty)
   );

   prus_back #(
      .MAX_SCALE (MAX_SCALE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .eff_scale  (eff_scale),
      .q_valid    (q_not_empty),
      .q_data     (q_rd_data),
      .q_rd_en    (q_rd_en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
